// ===== src/ktd_pkg.sv =====
// Shared types and constants for the key text decoder.
`default_nettype none
package ktd_pkg;

  localparam logic [1:0] ENC_RAW = 2'd0;
  localparam logic [1:0] ENC_HEX = 2'd1;
  localparam logic [1:0] ENC_B64 = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEX_ODD  = 3'd1;
  localparam logic [2:0] ST_HEX_BAD  = 3'd2;
  localparam logic [2:0] ST_MIXED    = 3'd3;
  localparam logic [2:0] ST_BAD_PAD  = 3'd4;
  localparam logic [2:0] ST_BAD_LEN  = 3'd5;
  localparam logic [2:0] ST_BAD_CHAR = 3'd6;
  localparam logic [2:0] ST_TRAIL    = 3'd7;

  typedef struct packed {
    logic [7:0] in_char;
    logic       char_present;
    logic       end_of_key;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_done;
    logic [2:0] status;
  } out_item_t;

  // Classified character, handed from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       last;
    logic       blank;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       b64_ok;
    logic [5:0] b64_val;
    logic       pad;
    logic       std_sym;
    logic       url_sym;
  } char_class_t;

endpackage
`default_nettype wire

// ===== src/key_text_decoder_hex_base64.sv =====
// Top level of the key text decoder (raw, hex, base64).
//
//   channel  dir  handshake             payload
//   in       in   in_valid/in_ready     in_data  (ktd_pkg::in_item_t)
//   out      out  out_valid/out_ready   out_data (ktd_pkg::out_item_t)
//   cfg      in   cfg_valid/cfg_ready   cfg_data (encoding code)
//
// One character per cycle while the output is not stalled; a character that
// also ends the key gives its byte, then its status. Throughput is set by the
// back end's two result slots; the QUEUE_DEPTH queue absorbs output stalls.
// Reset is synchronous and clears the queue, decoder state and encoding.
`default_nettype none
module key_text_decoder_hex_base64 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire ktd_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output ktd_pkg::out_item_t        out_data,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [1:0]                 cfg_data
);

  logic [1:0]           enc_mode;
  ktd_pkg::char_class_t cls;
  ktd_pkg::char_class_t head;
  logic                 q_full, q_nempty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_mode <= ktd_pkg::ENC_RAW;
    end else if (cfg_valid) begin
      enc_mode <= cfg_data;
    end
  end

  ktd_front u_front (
    .in_data (in_data),
    .cls     (cls)
  );

  ktd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (cls),
    .full      (q_full),
    .not_empty (q_nempty),
    .pop       (q_pop),
    .pop_data  (head)
  );

  ktd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .enc_mode  (enc_mode),
    .item_valid(q_nempty),
    .item      (head),
    .item_pop  (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== src/ktd_front.sv =====
// Front end: accepts characters and classifies them for the decoder.
`default_nettype none
module ktd_front (
  input  wire ktd_pkg::in_item_t    in_data,
  output ktd_pkg::char_class_t      cls
);

  logic [7:0] c;

  always_comb begin
    c           = in_data.in_char;
    cls.ch      = c;
    cls.present = in_data.char_present;
    cls.last    = in_data.end_of_key;
    cls.blank   = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    cls.pad     = (c == 8'h3D);
    cls.std_sym = (c == 8'h2B) || (c == 8'h2F);
    cls.url_sym = (c == 8'h2D) || (c == 8'h5F);

    cls.hex_ok  = 1'b1;
    cls.hex_val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      cls.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      cls.hex_val = 4'(c[3:0] + 4'd9);
    end else begin
      cls.hex_ok = 1'b0;
    end

    cls.b64_ok  = 1'b1;
    cls.b64_val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      cls.b64_val = 6'(c - 8'd65);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      cls.b64_val = 6'(c - 8'd71);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls.b64_val = 6'(c + 8'd4);
    end else if (cls.std_sym || cls.url_sym) begin
      cls.b64_val = (c == 8'h2B || c == 8'h2D) ? 6'd62 : 6'd63;
    end else begin
      cls.b64_ok = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/ktd_fifo.sv =====
// Short queue of classified characters between front and back.
`default_nettype none
module ktd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  input  wire ktd_pkg::char_class_t  push_data,
  output logic                       full,
  output logic                       not_empty,
  input  wire                        pop,
  output ktd_pkg::char_class_t       pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ktd_pkg::char_class_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");

endmodule
`default_nettype wire

// ===== src/ktd_back.sv =====
// Back end: decoder state, byte assembly, status and result slots.
`default_nettype none
module ktd_back (
  input  wire                        clk,
  input  wire                        rst,
  input  wire [1:0]                  enc_mode,
  input  wire                        item_valid,
  input  wire ktd_pkg::char_class_t  item,
  output logic                       item_pop,
  output logic                       out_valid,
  input  wire                        out_ready,
  output ktd_pkg::out_item_t         out_data
);

  logic [11:0] acc, acc_next;
  logic [3:0]  pb, pb_next;
  logic [3:0]  hn, hn_next;
  logic        par, par_next;
  logic [1:0]  dc, dc_next;
  logic [1:0]  pc, pc_next;
  logic        ps, ps_next;
  logic        cap, cap_next;
  logic        stds, stds_next;
  logic        urls, urls_next;
  logic        inv, inv_next;

  logic        byte_v, stat_v;
  logic [7:0]  byte_q;
  logic [2:0]  stat_q;

  logic        emit;
  logic [7:0]  ebyte;
  logic [2:0]  stat_c;
  logic [3:0]  pb_sum;
  logic [11:0] acc_sh;
  logic [11:0] mask;
  logic [1:0]  expected;
  logic        hex_mode, b64_mode, can_take;

  assign hex_mode = (enc_mode == ktd_pkg::ENC_HEX);
  assign b64_mode = (enc_mode == ktd_pkg::ENC_B64);

  always_comb begin
    acc_next  = acc;
    pb_next   = pb;
    hn_next   = hn;
    par_next  = par;
    dc_next   = dc;
    pc_next   = pc;
    ps_next   = ps;
    cap_next  = cap;
    stds_next = stds;
    urls_next = urls;
    inv_next  = inv;
    emit      = 1'b0;
    ebyte     = item.ch;
    acc_sh    = {acc[5:0], item.b64_val};
    pb_sum    = 4'(pb + 4'd6);

    if (item.present) begin
      if (!hex_mode && !b64_mode) begin
        emit = 1'b1;
      end else if (item.blank) begin
        emit = 1'b0;
      end else if (hex_mode) begin
        if (!par) begin
          par_next = 1'b1;
          if (!item.hex_ok) inv_next = 1'b1;
          else hn_next = item.hex_val;
        end else begin
          par_next = 1'b0;
          if (!item.hex_ok) begin
            inv_next = 1'b1;
          end else if (!inv) begin
            emit  = 1'b1;
            ebyte = {hn, item.hex_val};
          end
        end
      end else begin
        if (item.std_sym) stds_next = 1'b1;
        if (item.url_sym) urls_next = 1'b1;
        if (item.pad) begin
          ps_next = 1'b1;
          if (pc != 2'd3) pc_next = 2'(pc + 2'd1);
        end else if (ps) begin
          cap_next = 1'b1;
        end else begin
          dc_next = 2'(dc + 2'd1);
          if (!item.b64_ok) begin
            inv_next = 1'b1;
          end else if (!inv) begin
            acc_next = acc_sh;
            pb_next  = pb_sum;
            if (pb_sum >= 4'd8) begin
              pb_next = 4'(pb_sum - 4'd8);
              emit    = 1'b1;
              ebyte   = 8'(acc_sh >> 4'(pb_sum - 4'd8));
            end
          end
        end
      end
    end

    // status uses the state after this character
    expected = 2'(2'd0 - dc_next);
    mask     = 12'((12'd1 << pb_next) - 12'd1);
    stat_c   = ktd_pkg::ST_OK;
    if (hex_mode) begin
      if (par_next) stat_c = ktd_pkg::ST_HEX_ODD;
      else if (inv_next) stat_c = ktd_pkg::ST_HEX_BAD;
    end else if (b64_mode) begin
      if (stds_next && urls_next) begin
        stat_c = ktd_pkg::ST_MIXED;
      end else if (ps_next && (cap_next || pc_next == 2'd3 || expected != pc_next)) begin
        stat_c = ktd_pkg::ST_BAD_PAD;
      end else if (dc_next == 2'd1) begin
        stat_c = ktd_pkg::ST_BAD_LEN;
      end else if (inv_next) begin
        stat_c = ktd_pkg::ST_BAD_CHAR;
      end else if (pb_next != 4'd0 && pb_next < 4'd12 && (acc_next & mask) != 12'd0) begin
        stat_c = ktd_pkg::ST_TRAIL;
      end
    end

    if (item.last) begin
      acc_next  = '0;
      pb_next   = '0;
      hn_next   = '0;
      par_next  = 1'b0;
      dc_next   = '0;
      pc_next   = '0;
      ps_next   = 1'b0;
      cap_next  = 1'b0;
      stds_next = 1'b0;
      urls_next = 1'b0;
      inv_next  = 1'b0;
    end
  end

  assign can_take = (!byte_v && !stat_v) || (out_ready && (byte_v ^ stat_v));
  assign item_pop = item_valid && can_take;
  assign out_valid = byte_v || stat_v;

  always_comb begin
    out_data.out_byte     = byte_v ? byte_q : 8'd0;
    out_data.byte_present = byte_v;
    out_data.run_done     = !byte_v;
    out_data.status       = byte_v ? ktd_pkg::ST_OK : stat_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      pb     <= '0;
      hn     <= '0;
      par    <= 1'b0;
      dc     <= '0;
      pc     <= '0;
      ps     <= 1'b0;
      cap    <= 1'b0;
      stds   <= 1'b0;
      urls   <= 1'b0;
      inv    <= 1'b0;
      byte_v <= 1'b0;
      stat_v <= 1'b0;
    end else if (item_pop) begin
      acc    <= acc_next;
      pb     <= pb_next;
      hn     <= hn_next;
      par    <= par_next;
      dc     <= dc_next;
      pc     <= pc_next;
      ps     <= ps_next;
      cap    <= cap_next;
      stds   <= stds_next;
      urls   <= urls_next;
      inv    <= inv_next;
      byte_v <= emit;
      stat_v <= item.last;
    end else if (out_valid && out_ready) begin
      if (byte_v) byte_v <= 1'b0;
      else stat_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      byte_q <= ebyte;
      stat_q <= stat_c;
    end
  end

  a_pb_even: assert property (@(posedge clk) disable iff (rst)
    !pb[0] && pb <= 4'd6) else $error("pending bit count out of range");
  a_status_follows: assert property (@(posedge clk) disable iff (rst)
    byte_v && stat_v && out_ready |=> stat_v && !byte_v)
    else $error("status did not follow its byte");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result pending after reset");

endmodule
`default_nettype wire
